// ===== hdl/bstw_pkg.sv =====
// ----------------------------------------------------------------------------
// bstw_pkg: shared types for the bottleneck spanning tree weight block
// edge payload, queue entry and sequencer states
// ----------------------------------------------------------------------------
package bstw_pkg;

  localparam int unsigned LabelW  = 10;
  localparam int unsigned WeightW = 32;

  typedef struct packed {
    logic [LabelW-1:0]  node_a;
    logic [LabelW-1:0]  node_b;
    logic [WeightW-1:0] weight;
    logic               last_edge;
  } edge_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PUSH_RD,
    ST_PUSH_CMP,
    ST_PUSH_WR,
    ST_INIT,
    ST_POP_START,
    ST_POP_LAST,
    ST_POP_TOPW,
    ST_SIFT_RD,
    ST_SIFT_RDC,
    ST_SIFT_CMP,
    ST_EDGE_RD,
    ST_EDGE_GET,
    ST_FIND,
    ST_FIND_WAIT,
    ST_COMP,
    ST_COMP_WAIT,
    ST_LINK,
    ST_DONE
  } seq_state_e;

endpackage

// ===== hdl/bstw_if.sv =====
// ----------------------------------------------------------------------------
// bstw_if: valid/ready channel
// carries one payload per transaction
// ----------------------------------------------------------------------------
interface bstw_if #(
  parameter int unsigned Width = 1
);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/bottleneck_spanning_tree_weight.sv =====
// ----------------------------------------------------------------------------
// bottleneck_spanning_tree_weight: kruskal bottleneck weight over a min-heap
// per pushed edge a sift-up through the heap; the last edge starts parent init
// of all MaxNodes slots, then per edge a pop with sift-down, root walks with path
// compression and four link writes;
// one graph at a time; the heap and parent ram single ports set the pace
// reset: edge count, heap size, flag and answer clear; node_count is 1023
// ----------------------------------------------------------------------------
module bottleneck_spanning_tree_weight #(
  parameter int unsigned MaxNodes = 1024,
  parameter int unsigned MaxEdges = 4096
) (
  input  logic clk_i,
  input  logic rst_ni,
  bstw_if.sink   cfg,
  bstw_if.sink   edge_in,
  bstw_if.source res_out
);
  // node count register, to be written while idle; the block itself does not enforce it
  logic [9:0] node_count_q;

  // front to back queue
  bstw_pkg::edge_t q_data;
  logic            q_valid, q_pop;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= 10'd1023;
    end else if (cfg.valid && cfg.ready) begin
      node_count_q <= cfg.data[9:0];
    end
  end

  bstw_front u_front (
    .clk_i, .rst_ni, .edge_in,
    .q_data_o(q_data), .q_valid_o(q_valid), .q_pop_i(q_pop));

  bstw_back #(.MaxNodes(MaxNodes), .MaxEdges(MaxEdges)) u_back (
    .clk_i, .rst_ni, .node_count_i(node_count_q),
    .q_data_i(q_data), .q_valid_i(q_valid), .q_pop_o(q_pop), .res_out);
endmodule

// ===== hdl/bstw_ram.sv =====
// ----------------------------------------------------------------------------
// bstw_ram: generic single port ram
// one write or one read per cycle, registered read data
// ----------------------------------------------------------------------------
module bstw_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ===== hdl/bstw_front.sv =====
// ----------------------------------------------------------------------------
// bstw_front: edge intake
// accepts edges into a two-entry queue, passes on the last edge tag of each graph
// ----------------------------------------------------------------------------
module bstw_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  bstw_if.sink           edge_in,
  output bstw_pkg::edge_t q_data_o,
  output logic           q_valid_o,
  input  logic           q_pop_i
);
  bstw_pkg::edge_t buf_q [2];
  logic            rd_q, wr_q;
  logic [1:0]      cnt_q;
  logic            push;

  assign edge_in.ready = (cnt_q != 2'd2);
  assign push          = edge_in.valid && edge_in.ready;
  assign q_valid_o     = (cnt_q != 2'd0);
  assign q_data_o      = buf_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_q] <= edge_in.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (q_pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end
endmodule

// ===== hdl/bstw_back.sv =====
// ----------------------------------------------------------------------------
// bstw_back: heap and union-find sequencer
// pushes edges into a min-heap, then runs kruskal with path compression
// ----------------------------------------------------------------------------
module bstw_back #(
  parameter int unsigned MaxNodes = 1024,
  parameter int unsigned MaxEdges = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [9:0]            node_count_i,
  input  bstw_pkg::edge_t       q_data_i,
  input  logic                  q_valid_i,
  output logic                  q_pop_o,
  bstw_if.source                res_out
);
  localparam int unsigned NW = $clog2(MaxNodes);
  localparam int unsigned EW = (MaxEdges > 1) ? $clog2(MaxEdges) : 1;
  localparam int unsigned HW = $clog2(MaxEdges + 1);
  localparam int unsigned SW = HW + 1;
  localparam int unsigned HD = 1 << HW;
  localparam int unsigned EDW = 2 * bstw_pkg::LabelW + bstw_pkg::WeightW;

  bstw_pkg::seq_state_e state_q, state_d;

  // edge store
  logic           e_we;
  logic [EW-1:0]  e_addr;
  logic [EDW-1:0] e_wdata, e_rdata;
  // heap slots hold edge indexes, 1-based
  logic           h_we;
  logic [HW-1:0]  h_addr;
  logic [EW-1:0]  h_wdata, h_rdata;
  // key per heap slot kept alongside to avoid an extra read
  logic           k_we;
  logic [31:0]    k_wdata, k_rdata;
  // parent table
  logic           p_we;
  logic [NW-1:0]  p_addr, p_wdata, p_rdata;

  logic [SW-1:0]  ecount_q, hsize_q, l_q, r_q, c_q;
  logic           ovf_q;
  logic [31:0]    ans_q;
  logic [EW-1:0]  idx_q, last_idx_q, cidx_q;
  logic [31:0]    key_q, last_key_q, ckey_q;
  logic [NW-1:0]  init_q, x_q, rt_q, sa_q, sb_q, ra_q, rb_q;
  logic           side_q, fin_q;
  logic [31:0]    w_q;
  logic [2:0]     link_q;
  logic           out_v_q;
  logic [31:0]    out_w_q;
  logic           out_f_q;
  logic [NW-1:0]  lim;

  bstw_ram #(.Width(EDW), .Depth(1 << EW)) u_edges (
    .clk_i, .we_i(e_we), .addr_i(e_addr), .wdata_i(e_wdata), .rdata_o(e_rdata));
  bstw_ram #(.Width(EW), .Depth(HD)) u_heap (
    .clk_i, .we_i(h_we), .addr_i(h_addr), .wdata_i(h_wdata), .rdata_o(h_rdata));
  bstw_ram #(.Width(32), .Depth(HD)) u_keys (
    .clk_i, .we_i(k_we), .addr_i(h_addr), .wdata_i(k_wdata), .rdata_o(k_rdata));
  bstw_ram #(.Width(NW), .Depth(MaxNodes)) u_parent (
    .clk_i, .we_i(p_we), .addr_i(p_addr), .wdata_i(p_wdata), .rdata_o(p_rdata));

  function automatic logic [NW-1:0] slot_of(input logic [9:0] lbl);
    logic [NW-1:0] r;
    r = '0;
    if ({22'd0, lbl} < MaxNodes) r = NW'(lbl);
    return r;
  endfunction

  always_comb begin
    lim = (32'(node_count_i) < MaxNodes) ? NW'(node_count_i) : NW'(MaxNodes - 1);
  end

  assign res_out.valid = out_v_q;
  assign res_out.data  = {out_w_q, out_f_q};

  logic store_ok;
  assign store_ok = (ecount_q < SW'(MaxEdges));

  // sift-down compare: pick smaller child, stop if last is not larger
  logic          sift_r, sift_stop;
  logic [31:0]   sift_k;
  logic [EW-1:0] sift_i;
  logic [SW-1:0] sift_c;
  assign sift_r    = (c_q < hsize_q) && (ckey_q > k_rdata);
  assign sift_k    = sift_r ? k_rdata : ckey_q;
  assign sift_i    = sift_r ? h_rdata : cidx_q;
  assign sift_c    = sift_r ? c_q + SW'(1) : c_q;
  assign sift_stop = (sift_k >= last_key_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bstw_pkg::ST_IDLE: begin
        if (q_valid_i && !out_v_q) begin
          if (store_ok) state_d = (hsize_q == '0) ? bstw_pkg::ST_PUSH_WR
                                                  : bstw_pkg::ST_PUSH_RD;
          else if (q_data_i.last_edge) state_d = bstw_pkg::ST_INIT;
        end
      end
      bstw_pkg::ST_PUSH_RD:   state_d = bstw_pkg::ST_PUSH_CMP;
      bstw_pkg::ST_PUSH_CMP: begin
        // stop once the new key is not smaller than its parent or has moved up to the root
        if ((key_q < k_rdata) && ((l_q >> 1) != SW'(1))) state_d = bstw_pkg::ST_PUSH_RD;
        else state_d = bstw_pkg::ST_PUSH_WR;
      end
      bstw_pkg::ST_PUSH_WR:   state_d = fin_q ? bstw_pkg::ST_INIT : bstw_pkg::ST_IDLE;
      bstw_pkg::ST_INIT: begin
        if (32'(init_q) == MaxNodes - 1)
          state_d = (hsize_q == '0) ? bstw_pkg::ST_DONE : bstw_pkg::ST_POP_START;
      end
      bstw_pkg::ST_POP_START: state_d = bstw_pkg::ST_POP_LAST;
      bstw_pkg::ST_POP_LAST:  state_d = bstw_pkg::ST_POP_TOPW;
      bstw_pkg::ST_POP_TOPW:  state_d = bstw_pkg::ST_SIFT_RD;
      bstw_pkg::ST_SIFT_RD: begin
        if ({r_q, 1'b0} > {1'b0, hsize_q}) state_d = bstw_pkg::ST_EDGE_RD;
        else state_d = bstw_pkg::ST_SIFT_RDC;
      end
      bstw_pkg::ST_SIFT_RDC:  state_d = bstw_pkg::ST_SIFT_CMP;
      bstw_pkg::ST_SIFT_CMP:  state_d = sift_stop ? bstw_pkg::ST_EDGE_RD
                                                  : bstw_pkg::ST_SIFT_RD;
      bstw_pkg::ST_EDGE_RD:   state_d = bstw_pkg::ST_EDGE_GET;
      bstw_pkg::ST_EDGE_GET:  state_d = bstw_pkg::ST_FIND;
      bstw_pkg::ST_FIND:      state_d = bstw_pkg::ST_FIND_WAIT;
      bstw_pkg::ST_FIND_WAIT: begin
        if (p_rdata == x_q) state_d = bstw_pkg::ST_COMP;
        else state_d = bstw_pkg::ST_FIND;
      end
      bstw_pkg::ST_COMP:      state_d = bstw_pkg::ST_COMP_WAIT;
      bstw_pkg::ST_COMP_WAIT: begin
        if (x_q == rt_q) state_d = side_q ? bstw_pkg::ST_LINK : bstw_pkg::ST_FIND;
        else state_d = bstw_pkg::ST_COMP;
      end
      bstw_pkg::ST_LINK: begin
        if (link_q == 3'd3)
          state_d = (hsize_q == '0) ? bstw_pkg::ST_DONE : bstw_pkg::ST_POP_START;
      end
      bstw_pkg::ST_DONE:      state_d = bstw_pkg::ST_IDLE;
      default:                state_d = bstw_pkg::ST_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    logic [NW-1:0] m;
    m       = (ra_q < rb_q) ? ra_q : rb_q;
    q_pop_o = 1'b0;
    e_we = 1'b0; e_addr = ecount_q[EW-1:0];
    e_wdata = {q_data_i.node_a, q_data_i.node_b, q_data_i.weight};
    h_we = 1'b0; h_addr = l_q[HW-1:0]; h_wdata = idx_q; k_we = 1'b0; k_wdata = key_q;
    p_we = 1'b0; p_addr = x_q; p_wdata = rt_q;
    unique case (state_q)
      bstw_pkg::ST_IDLE: begin
        if (q_valid_i && !out_v_q) begin
          q_pop_o = 1'b1;
          e_we    = store_ok;
        end
      end
      bstw_pkg::ST_PUSH_RD:  h_addr = HW'(l_q >> 1);
      bstw_pkg::ST_PUSH_CMP: begin
        // move parent down when the new key is smaller
        h_addr = l_q[HW-1:0];
        h_wdata = h_rdata; k_wdata = k_rdata;
        h_we = (key_q < k_rdata); k_we = h_we;
      end
      bstw_pkg::ST_PUSH_WR: begin h_we = 1'b1; k_we = 1'b1; end
      bstw_pkg::ST_INIT: begin
        p_we = 1'b1; p_addr = init_q;
        p_wdata = (init_q <= lim) ? init_q : '0;
      end
      bstw_pkg::ST_POP_START: h_addr = HW'(1);
      // last slot before the pop shrank the heap
      bstw_pkg::ST_POP_LAST:  h_addr = hsize_q[HW-1:0] + HW'(1);
      bstw_pkg::ST_POP_TOPW:  h_addr = hsize_q[HW-1:0];
      bstw_pkg::ST_SIFT_RD: begin
        h_addr = c_q[HW-1:0];
        if ({r_q, 1'b0} > {1'b0, hsize_q}) begin
          h_addr = r_q[HW-1:0]; h_we = 1'b1; k_we = 1'b1;
          h_wdata = last_idx_q; k_wdata = last_key_q;
        end
      end
      bstw_pkg::ST_SIFT_RDC:  h_addr = c_q[HW-1:0] + HW'(1);
      bstw_pkg::ST_SIFT_CMP: begin
        // child moves up into slot r, or the last entry settles there
        h_addr = r_q[HW-1:0]; h_we = 1'b1; k_we = 1'b1;
        h_wdata = sift_stop ? last_idx_q : sift_i;
        k_wdata = sift_stop ? last_key_q : sift_k;
      end
      bstw_pkg::ST_EDGE_RD:   e_addr = idx_q;
      bstw_pkg::ST_FIND:      p_addr = x_q;
      bstw_pkg::ST_COMP:      p_addr = x_q;
      bstw_pkg::ST_COMP_WAIT: begin
        p_addr = x_q; p_we = (x_q != rt_q); p_wdata = rt_q;
      end
      bstw_pkg::ST_LINK: begin
        p_we = 1'b1; p_wdata = m;
        unique case (link_q)
          3'd0:    p_addr = sa_q;
          3'd1:    p_addr = ra_q;
          3'd2:    p_addr = sb_q;
          default: p_addr = rb_q;
        endcase
      end
      default: ;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      bstw_pkg::ST_IDLE: begin
        idx_q <= ecount_q[EW-1:0];
        key_q <= q_data_i.weight ^ 32'h8000_0000;
        fin_q <= q_data_i.last_edge;
        l_q   <= hsize_q + SW'(1);
      end
      bstw_pkg::ST_PUSH_CMP: if (key_q < k_rdata) l_q <= l_q >> 1;
      bstw_pkg::ST_PUSH_RD: begin
        if ((l_q >> 1) == '0) l_q <= l_q;
      end
      bstw_pkg::ST_INIT: init_q <= init_q + NW'(1);
      bstw_pkg::ST_POP_LAST: begin
        idx_q <= h_rdata;
        r_q   <= SW'(1);
        c_q   <= SW'(2);
      end
      bstw_pkg::ST_POP_TOPW: begin
        last_idx_q <= h_rdata; last_key_q <= k_rdata;
      end
      bstw_pkg::ST_SIFT_RDC: begin cidx_q <= h_rdata; ckey_q <= k_rdata; end
      bstw_pkg::ST_SIFT_CMP: begin
        if (!sift_stop) begin
          r_q <= sift_c;
          c_q <= sift_c << 1;
        end
      end
      bstw_pkg::ST_EDGE_GET: begin
        sa_q <= slot_of(e_rdata[EDW-1 -: 10]);
        sb_q <= slot_of(e_rdata[EDW-11 -: 10]);
        x_q  <= slot_of(e_rdata[EDW-1 -: 10]);
        w_q  <= e_rdata[31:0];
        side_q <= 1'b0;
      end
      bstw_pkg::ST_FIND_WAIT: begin
        if (p_rdata == x_q) begin
          rt_q <= x_q;
          x_q  <= side_q ? sb_q : sa_q;
          if (side_q) rb_q <= x_q; else ra_q <= x_q;
        end else x_q <= p_rdata;
      end
      bstw_pkg::ST_COMP_WAIT: begin
        if (x_q == rt_q) begin
          side_q <= 1'b1;
          x_q    <= sb_q;
          link_q <= 3'd0;
        end else x_q <= p_rdata;
      end
      bstw_pkg::ST_LINK: link_q <= link_q + 3'd1;
      default: ;
    endcase
    if (state_q == bstw_pkg::ST_PUSH_WR || state_q == bstw_pkg::ST_IDLE) init_q <= '0;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= bstw_pkg::ST_IDLE;
      ecount_q <= '0;
      hsize_q  <= '0;
      ovf_q    <= 1'b0;
      ans_q    <= '0;
      out_v_q  <= 1'b0;
      out_w_q  <= '0;
      out_f_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (res_out.valid && res_out.ready) out_v_q <= 1'b0;
      unique case (state_q)
        bstw_pkg::ST_IDLE: begin
          if (q_valid_i && !out_v_q) begin
            if (store_ok) ecount_q <= ecount_q + SW'(1);
            else ovf_q <= 1'b1;
          end
        end
        bstw_pkg::ST_PUSH_WR:   hsize_q <= hsize_q + SW'(1);
        bstw_pkg::ST_INIT:      ans_q <= '0;
        bstw_pkg::ST_POP_START: hsize_q <= hsize_q - SW'(1);
        bstw_pkg::ST_LINK: begin
          if (link_q == 3'd0 && (ra_q != NW'(1) || rb_q != NW'(1))) ans_q <= w_q;
        end
        bstw_pkg::ST_DONE: begin
          out_v_q  <= 1'b1;
          out_w_q  <= ans_q;
          out_f_q  <= ovf_q;
          ovf_q    <= 1'b0;
          ecount_q <= '0;
          hsize_q  <= '0;
        end
        default: ;
      endcase
    end
  end
endmodule
